FILE: src/alpt_pkg.sv
// Shared widths, codes and inter-stage bundles of the profile time core.
`timescale 1ns / 1ps
package alpt_pkg;

  localparam int VAL_W  = 32;            // input positions and velocities
  localparam int LIM_W  = 31;            // velocity and acceleration limit registers
  localparam int TOL_W  = 16;            // tolerance register
  localparam int ADDR_W = 4;             // configuration byte address
  localparam int NUM_W  = 70;            // signed time numerator
  localparam int RAD_W  = 68;            // square-root radicand
  localparam int ROOT_W = RAD_W / 2;     // square-root result
  localparam int DEN_W  = 64;            // time denominator
  localparam int QT_W   = 32;            // profile time

  localparam logic [QT_W-1:0] TIME_MAX = 32'h7FFF_FFFF;
  localparam logic [QT_W-1:0] TIME_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    OP_LHL      = 3'd0,
    OP_LL       = 3'd1,
    OP_TRI_NEG  = 3'd2,
    OP_TRAP_NEG = 3'd3,
    OP_NEG_POS  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_VLIM = 2'd0,
    REG_ALIM = 2'd1,
    REG_TOL  = 2'd2
  } reg_idx_t;

  // Work that travels with a beat after the feasibility checks are done.
  typedef struct packed {
    op_t                      op;
    logic                     ok;
    logic signed [NUM_W-1:0]  num03;
    logic signed [VAL_W:0]    vsum;
    logic [DEN_W-1:0]         den;
  } job_t;

endpackage

FILE: src/alpt_front.sv
// Front pipeline: products, sums, feasibility checks and radicand selection.
`timescale 1ns / 1ps
module alpt_front import alpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic [2:0]              in_operation,
  input  logic signed [VAL_W-1:0] in_start_position,
  input  logic signed [VAL_W-1:0] in_start_velocity,
  input  logic signed [VAL_W-1:0] in_goal_position,
  input  logic signed [VAL_W-1:0] in_goal_velocity,
  input  logic [LIM_W-1:0]        vlim,
  input  logic [LIM_W-1:0]        alim,
  input  logic [TOL_W-1:0]        tol,
  output logic                    out_valid,
  output job_t                    out_job,
  output logic [RAD_W-1:0]        out_rad
);

  logic [7:0] v_r;

  // Stage 1: products.
  logic [LIM_W-1:0]        veff, aeff;
  logic signed [VAL_W-1:0] vs_in, as_in;
  op_t                     op1_r;
  logic signed [63:0]      apt_r, apc_r, vc2_r, vt2_r, vvc_r, vvt_r;
  logic [61:0]             vv_r, av_r, aa1_r;
  logic signed [VAL_W-1:0] vc1_r, vt1_r;
  logic [LIM_W-1:0]        v1_r, a1_r;
  logic [TOL_W-1:0]        e1_r;

  // Stage 2.
  op_t                     op2_r;
  logic signed [65:0]      ad2_r, sq_r;
  logic signed [66:0]      ext2_r;
  logic [62:0]             twov2_r;
  logic [DEN_W-1:0]        den2_r;
  logic [63:0]             tvc2_r, tvt2_r;
  logic                    vcin2_r, vtpos2_r, vtneg2_r;
  logic signed [VAL_W:0]   vsum2_r;
  logic [LIM_W-1:0]        a2_r;
  logic [61:0]             aa2_r;
  logic [TOL_W-1:0]        e2_r;
  logic signed [VAL_W-1:0] vlim_s;

  // Stage 3.
  op_t                     op3_r;
  logic signed [66:0]      x_r, y_r, ext3_r;
  logic [62:0]             twov3_r;
  logic [DEN_W-1:0]        den3_r;
  logic [63:0]             tvc3_r, tvt3_r;
  logic                    vcin3_r, vtpos3_r, vtneg3_r;
  logic signed [VAL_W:0]   vsum3_r;
  logic [LIM_W-1:0]        a3_r;
  logic [61:0]             aa3_r;
  logic [TOL_W-1:0]        e3_r;

  // Stage 4 logic.
  logic signed [67:0]      diff4;
  logic [67:0]             etol4;
  logic                    tol_ok, xc_le, vc_le, vt_le, ok4, need4;
  logic [65:0]             xc4;
  logic [RAD_W-1:0]        rad4;
  logic [DEN_W-1:0]        den4;

  // Stages 4 to 8.
  job_t                    job4_r, job5_r, job6_r, job7_r, job8_r;
  job_t                    job8_nxt;
  logic [RAD_W-1:0]        rad4_r, rad5_r, rad6_r, rad7_r, rad8_r;
  logic                    need4_r, need5_r, need6_r, need7_r;
  logic [65:0]             negx_r;
  logic [61:0]             aa4_r;
  logic [TOL_W-1:0]        e4_r, e5_r, e6_r, e7_r;
  logic [63:0]             p00_r, p01_r, p10_r, p11_r;
  logic [127:0]            sa_r, sb_r, prod_r;
  logic [127:0]            etol8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[6:0], in_valid};
    end
  end

  assign veff  = (vlim == '0) ? LIM_W'(1) : vlim;
  assign aeff  = (alim == '0) ? LIM_W'(1) : alim;
  assign vs_in = $signed({1'b0, veff});
  assign as_in = $signed({1'b0, aeff});

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r <= op_t'(in_operation);
      apt_r <= as_in * in_goal_position;
      apc_r <= as_in * in_start_position;
      vc2_r <= in_start_velocity * in_start_velocity;
      vt2_r <= in_goal_velocity * in_goal_velocity;
      vvc_r <= vs_in * in_start_velocity;
      vvt_r <= vs_in * in_goal_velocity;
      vv_r  <= 62'(veff) * 62'(veff);
      av_r  <= 62'(aeff) * 62'(veff);
      aa1_r <= 62'(aeff) * 62'(aeff);
      vc1_r <= in_start_velocity;
      vt1_r <= in_goal_velocity;
      v1_r  <= veff;
      a1_r  <= aeff;
      e1_r  <= tol;
    end
  end

  assign vlim_s = $signed({1'b0, v1_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      op2_r    <= op1_r;
      ad2_r    <= (66'(apt_r) - 66'(apc_r)) <<< 1;
      sq_r     <= 66'(vc2_r) + 66'(vt2_r);
      ext2_r   <= (67'($signed({1'b0, vv_r})) - 67'(vvc_r) - 67'(vvt_r)) <<< 1;
      twov2_r  <= {vv_r, 1'b0};
      den2_r   <= {1'b0, av_r, 1'b0};
      tvc2_r   <= {vc2_r[62:0], 1'b0};
      tvt2_r   <= {vt2_r[62:0], 1'b0};
      vcin2_r  <= (vc1_r >= 0) && (vc1_r <= vlim_s);
      vtpos2_r <= (vt1_r >= 0) && (vt1_r <= vlim_s);
      vtneg2_r <= (vt1_r <= 0) && (vt1_r >= -vlim_s);
      vsum2_r  <= 33'(vc1_r) + 33'(vt1_r);
      a2_r     <= a1_r;
      aa2_r    <= aa1_r;
      e2_r     <= e1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op3_r    <= op2_r;
      x_r      <= 67'(ad2_r) + 67'(sq_r);
      y_r      <= 67'(sq_r) - 67'(ad2_r);
      ext3_r   <= ext2_r;
      twov3_r  <= twov2_r;
      den3_r   <= den2_r;
      tvc3_r   <= tvc2_r;
      tvt3_r   <= tvt2_r;
      vcin3_r  <= vcin2_r;
      vtpos3_r <= vtpos2_r;
      vtneg3_r <= vtneg2_r;
      vsum3_r  <= vsum2_r;
      a3_r     <= a2_r;
      aa3_r    <= aa2_r;
      e3_r     <= e2_r;
    end
  end

  // Stage 4: the checks that need only X, and the radicand for the root.
  always_comb begin
    diff4  = 68'(x_r) - 68'($signed({1'b0, twov3_r}));
    etol4  = 68'(e3_r) << FRAC_BITS;
    tol_ok = diff4 >= -$signed(etol4);
    xc4    = x_r[66] ? '0 : x_r[65:0];
    xc_le  = xc4 <= 66'(twov3_r);
    vc_le  = 66'(tvc3_r) <= xc4;
    vt_le  = 66'(tvt3_r) <= xc4;
    rad4   = RAD_W'({xc4, 1'b0});
    den4   = den3_r;
    ok4    = 1'b0;
    need4  = 1'b0;
    case (op3_r)
      OP_LHL: begin
        ok4 = vcin3_r && tol_ok && vtpos3_r;
      end
      OP_TRAP_NEG: begin
        ok4 = vcin3_r && tol_ok && vtneg3_r;
      end
      OP_LL: begin
        ok4   = vcin3_r && vtpos3_r && xc_le && vc_le && vt_le;
        need4 = x_r[66];
        den4  = DEN_W'(a3_r);
      end
      OP_TRI_NEG: begin
        ok4   = vcin3_r && vtneg3_r && xc_le && vc_le;
        need4 = x_r[66];
        den4  = DEN_W'(a3_r);
      end
      OP_NEG_POS: begin
        ok4  = 1'b1;
        den4 = DEN_W'(a3_r);
        rad4 = y_r[66] ? '0 : RAD_W'({y_r[65:0], 1'b0});
      end
      default: begin
        den4 = DEN_W'(a3_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job4_r.op    <= op3_r;
      job4_r.ok    <= ok4;
      job4_r.num03 <= 70'(x_r) + 70'(ext3_r);
      job4_r.vsum  <= vsum3_r;
      job4_r.den   <= den4;
      rad4_r       <= rad4;
      need4_r      <= need4;
      negx_r       <= 66'(-x_r);
      aa4_r        <= aa3_r;
      e4_r         <= e3_r;
    end
  end

  // Stages 5 to 7: -X * A^2 for the tolerance test of a negative X.
  always_ff @(posedge clk) begin
    if (adv) begin
      job5_r  <= job4_r;
      rad5_r  <= rad4_r;
      need5_r <= need4_r;
      e5_r    <= e4_r;
      p00_r   <= 64'(negx_r[32:0]) * 64'(aa4_r[30:0]);
      p01_r   <= 64'(negx_r[32:0]) * 64'(aa4_r[61:31]);
      p10_r   <= 64'(negx_r[65:33]) * 64'(aa4_r[30:0]);
      p11_r   <= 64'(negx_r[65:33]) * 64'(aa4_r[61:31]);

      job6_r  <= job5_r;
      rad6_r  <= rad5_r;
      need6_r <= need5_r;
      e6_r    <= e5_r;
      sa_r    <= 128'(p00_r) + (128'(p01_r) << 31);
      sb_r    <= (128'(p10_r) << 33) + (128'(p11_r) << 64);

      job7_r  <= job6_r;
      rad7_r  <= rad6_r;
      need7_r <= need6_r;
      e7_r    <= e6_r;
      prod_r  <= sa_r + sb_r;
    end
  end

  assign etol8 = 128'(e7_r) << (3 * FRAC_BITS);

  always_comb begin
    job8_nxt    = job7_r;
    job8_nxt.ok = job7_r.ok && !(need7_r && (prod_r > etol8));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job8_r <= job8_nxt;
      rad8_r <= rad7_r;
    end
  end

  assign out_valid = v_r[7];
  assign out_job   = job8_r;
  assign out_rad   = rad8_r;

endmodule

FILE: src/alpt_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module alpt_sqrt import alpt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  job_t              in_job,
  input  logic [RAD_W-1:0]  in_rad,
  output logic              out_valid,
  output job_t              out_job,
  output logic [ROOT_W-1:0] out_root
);

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W+1:0] rem;
    logic [ROOT_W-1:0] root;
  } sq_st_t;

  sq_st_t            st_r   [ROOT_W];
  sq_st_t            st_nxt [ROOT_W];
  job_t              job_r  [ROOT_W];
  logic [ROOT_W-1:0] v_r;

  always_comb begin
    sq_st_t            src;
    logic [ROOT_W+1:0] rem2;
    logic [ROOT_W+1:0] trial;
    logic              ge;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        src.rad  = in_rad;
        src.rem  = '0;
        src.root = '0;
      end else begin
        src = st_r[k-1];
      end
      rem2  = {src.rem[ROOT_W-1:0], src.rad[RAD_W-1 -: 2]};
      trial = {src.root, 2'b01};
      ge    = rem2 >= trial;
      st_nxt[k].rad  = src.rad << 2;
      st_nxt[k].rem  = ge ? (rem2 - trial) : rem2;
      st_nxt[k].root = {src.root[ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[ROOT_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < ROOT_W; k++) begin
        st_r[k]  <= st_nxt[k];
        job_r[k] <= (k == 0) ? in_job : job_r[k-1];
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_job   = job_r[ROOT_W-1];
  assign out_root  = st_r[ROOT_W-1].root;

endmodule

FILE: src/alpt_div.sv
// Numerator selection, pipelined restoring divide, rounding and saturation.
`timescale 1ns / 1ps
module alpt_div import alpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  job_t              in_job,
  input  logic [ROOT_W-1:0] in_root,
  output logic              out_valid,
  output logic [QT_W-1:0]   out_time,
  output logic              out_ok
);

  localparam int SAT_SH = QT_W - FRAC_BITS;
  localparam int CMP_W  = NUM_W + QT_W;
  localparam int VD     = QT_W + 3;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QT_W-1:0]  q;
    logic [QT_W-1:0]  low;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             sat;
    logic             ok;
  } dv_st_t;

  logic [VD-1:0]           v_r;
  logic signed [NUM_W-1:0] num_nxt, num_r;
  logic [DEN_W-1:0]        den0_r;
  logic                    ok0_r;
  logic [NUM_W-1:0]        mag;
  dv_st_t                  d1_nxt, d1_r;
  dv_st_t                  st_r   [QT_W];
  dv_st_t                  st_nxt [QT_W];
  dv_st_t                  fin;
  logic [QT_W:0]           mq, negmq;
  logic [QT_W-1:0]         time_nxt, time_r;
  logic                    ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[VD-2:0], in_valid};
    end
  end

  always_comb begin
    case (in_job.op)
      OP_LHL, OP_TRAP_NEG: num_nxt = in_job.num03;
      OP_LL, OP_TRI_NEG:   num_nxt = NUM_W'($signed({1'b0, in_root})) - NUM_W'(in_job.vsum);
      OP_NEG_POS:          num_nxt = NUM_W'(in_job.vsum) - NUM_W'($signed({1'b0, in_root}));
      default:             num_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r  <= num_nxt;
      den0_r <= in_job.den;
      ok0_r  <= in_job.ok;
    end
  end

  // A quotient of 2^32 or more is known to saturate; otherwise the top part
  // of the dividend is already below the divisor.
  always_comb begin
    mag        = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
    d1_nxt.sat = CMP_W'(mag) >= (CMP_W'(den0_r) << SAT_SH);
    d1_nxt.rem = DEN_W'(mag >> SAT_SH);
    d1_nxt.low = QT_W'(mag << FRAC_BITS);
    d1_nxt.q   = '0;
    d1_nxt.den = den0_r;
    d1_nxt.neg = num_r[NUM_W-1];
    d1_nxt.ok  = ok0_r;
  end

  always_comb begin
    dv_st_t           src;
    logic [DEN_W:0]   r2;
    logic [DEN_W:0]   sub;
    logic             ge;
    for (int k = 0; k < QT_W; k++) begin
      src = (k == 0) ? d1_r : st_r[k-1];
      r2  = {src.rem, src.low[QT_W-1]};
      sub = r2 - {1'b0, src.den};
      ge  = r2 >= {1'b0, src.den};
      st_nxt[k]     = src;
      st_nxt[k].rem = ge ? sub[DEN_W-1:0] : r2[DEN_W-1:0];
      st_nxt[k].q   = {src.q[QT_W-2:0], ge};
      st_nxt[k].low = src.low << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r <= d1_nxt;
      for (int k = 0; k < QT_W; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // Negative numerators round toward minus infinity: bump the magnitude
  // when the remainder is not zero.
  always_comb begin
    fin   = st_r[QT_W-1];
    mq    = {1'b0, fin.q} + (QT_W+1)'(fin.rem != '0);
    negmq = -mq;
    if (fin.sat) begin
      time_nxt = fin.neg ? TIME_MIN : TIME_MAX;
    end else if (!fin.neg) begin
      time_nxt = fin.q[QT_W-1] ? TIME_MAX : fin.q;
    end else if (mq > {1'b0, TIME_MIN}) begin
      time_nxt = TIME_MIN;
    end else begin
      time_nxt = negmq[QT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      time_r <= time_nxt;
      ok_r   <= fin.ok;
    end
  end

  assign out_valid = v_r[VD-1];
  assign out_time  = time_r;
  assign out_ok    = ok_r;

endmodule

FILE: src/accel_limited_profile_time_core.sv
// Top level of the acceleration-limited profile time core.
`timescale 1ns / 1ps
//
//  Channel   Ports                                  Beat taken when
//  --------  -------------------------------------  ----------------------------
//  input     in_valid, in_stall, in_operation, ...  in_valid && !in_stall
//  result    out_valid, out_stall, out_profile_time  out_valid && !out_stall
//  config    psel, penable, pwrite, paddr, pwdata   psel && penable && pwrite
//
// A new beat can enter on every clock cycle while in_stall is low. An accepted
// input beat passes through 8 front stages of products and checks, 34 square-root
// stages (one root bit each), 35 divider stages (one quotient bit each plus setup
// and rounding) and the output register before its result shows on out_valid.
// Reset is synchronous and active low; it clears all valid bits and loads the
// limit registers with 1.0 and the tolerance with one LSB.
// The whole pipeline holds only while its last stage is full and the output
// register is full and stalled, so a waiting result does not block new input.
module accel_limited_profile_time_core import alpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_operation,
  input  logic signed [VAL_W-1:0] in_start_position,
  input  logic signed [VAL_W-1:0] in_start_velocity,
  input  logic signed [VAL_W-1:0] in_goal_position,
  input  logic signed [VAL_W-1:0] in_goal_velocity,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [QT_W-1:0]  out_profile_time,
  output logic                    out_solution_possible,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [LIM_W-1:0]  vlim_r, alim_r;
  logic [TOL_W-1:0]  tol_r;
  logic              cfg_wr;
  logic              adv;

  logic              fr_valid;
  job_t              fr_job;
  logic [RAD_W-1:0]  fr_rad;
  logic              sq_valid;
  job_t              sq_job;
  logic [ROOT_W-1:0] sq_root;
  logic              dv_valid;
  logic [QT_W-1:0]   dv_time;
  logic              dv_ok;

  logic              out_valid_r;
  logic [QT_W-1:0]   time_r;
  logic              ok_r;

  // Register file. Writes take effect on the access phase of the transfer.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlim_r <= LIM_W'(32'd1 << FRAC_BITS);
      alim_r <= LIM_W'(32'd1 << FRAC_BITS);
      tol_r  <= TOL_W'(1);
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_VLIM: vlim_r <= pwdata[LIM_W-1:0];
        REG_ALIM: alim_r <= pwdata[LIM_W-1:0];
        REG_TOL:  tol_r  <= pwdata[TOL_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_VLIM: prdata = {1'b0, vlim_r};
      REG_ALIM: prdata = {1'b0, alim_r};
      REG_TOL:  prdata = {16'd0, tol_r};
      default:  prdata = '0;
    endcase
  end

  // One enable for every pipeline stage. Bubbles ahead of the last stage
  // still squeeze out while a result waits in the output register.
  assign adv      = !(dv_valid && out_valid_r && out_stall);
  assign in_stall = !adv;

  alpt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv               (adv),
    .in_valid          (in_valid),
    .in_operation      (in_operation),
    .in_start_position (in_start_position),
    .in_start_velocity (in_start_velocity),
    .in_goal_position  (in_goal_position),
    .in_goal_velocity  (in_goal_velocity),
    .vlim              (vlim_r),
    .alim              (alim_r),
    .tol               (tol_r),
    .out_valid         (fr_valid),
    .out_job           (fr_job),
    .out_rad           (fr_rad)
  );

  alpt_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (fr_valid),
    .in_job    (fr_job),
    .in_rad    (fr_rad),
    .out_valid (sq_valid),
    .out_job   (sq_job),
    .out_root  (sq_root)
  );

  alpt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (sq_valid),
    .in_job    (sq_job),
    .in_root   (sq_root),
    .out_valid (dv_valid),
    .out_time  (dv_time),
    .out_ok    (dv_ok)
  );

  // Output register: it keeps its beat while stalled and otherwise takes
  // whatever the last divider stage holds, bubble or not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!(out_valid_r && out_stall)) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!(out_valid_r && out_stall)) begin
      time_r <= dv_time;
      ok_r   <= dv_ok;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_profile_time      = $signed(time_r);
  assign out_solution_possible = ok_r;

endmodule

FILE: tb/profile_time_checker.sv
// Checker for the profile time core: predicts each result and compares it.
`timescale 1ns / 1ps
module profile_time_checker import alpt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [2:0]              in_operation,
  input  logic signed [VAL_W-1:0] in_start_position,
  input  logic signed [VAL_W-1:0] in_start_velocity,
  input  logic signed [VAL_W-1:0] in_goal_position,
  input  logic signed [VAL_W-1:0] in_goal_velocity,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [QT_W-1:0]  out_profile_time,
  input  logic                    out_solution_possible,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic                    pready,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output int                      mismatches,
  output int                      pending
);

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [QT_W-1:0] duration;
    logic            feasible;
  } profile_t;

  profile_t        awaited[$];
  logic [LIM_W-1:0] vel_limit;
  logic [LIM_W-1:0] acc_limit;
  logic [TOL_W-1:0] tolerance;

  function automatic wide_t int_sqrt(wide_t n);
    wide_t root;
    wide_t trial;
    root = 0;
    for (int b = 40; b >= 0; b--) begin
      trial = root | (wide_t'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // The square root of twice the radicand, zero for a negative radicand.
  function automatic wide_t root_of_twice(wide_t x);
    return (x < 0) ? wide_t'(0) : int_sqrt(x * 2);
  endfunction

  // Floor of num * 2^16 / den, saturated to the 32-bit signed range.
  function automatic logic [QT_W-1:0] floor_time(wide_t num, wide_t den);
    wide_t scaled;
    wide_t q;
    scaled = num * 65536;
    q = scaled / den;
    if (scaled < 0 && (scaled % den) != 0) q = q - 1;
    if (q < -wide_t'(64'sh8000_0000)) return TIME_MIN;
    if (q > wide_t'(64'sh7FFF_FFFF)) return TIME_MAX;
    return q[QT_W-1:0];
  endfunction

  function automatic profile_t predict_profile(logic [2:0] op, wide_t pc, wide_t vc,
                                               wide_t pt, wide_t vt);
    profile_t res;
    wide_t v, a, e, dist2a, squares, rad, peak2, lim, clipped;
    v = (vel_limit == 0) ? wide_t'(1) : wide_t'({1'b0, vel_limit});
    a = (acc_limit == 0) ? wide_t'(1) : wide_t'({1'b0, acc_limit});
    e = wide_t'({1'b0, tolerance});
    dist2a = 2 * a * (pt - pc);
    squares = vc * vc + vt * vt;
    rad = dist2a + squares;
    peak2 = 2 * v * v;
    res.duration = '0;
    res.feasible = 1'b0;
    case (op)
      OP_LHL, OP_TRAP_NEG: begin
        res.duration = floor_time(rad + 2 * v * (v - vc - vt), 2 * a * v);
        res.feasible = vc >= 0 && vc <= v && (rad - peak2) >= -(e * 65536);
        if (op == OP_LHL) res.feasible &= vt >= 0 && vt <= v;
        else res.feasible &= vt <= 0 && vt >= -v;
      end
      OP_LL, OP_TRI_NEG: begin
        res.duration = floor_time(root_of_twice(rad) - vc - vt, a);
        res.feasible = vc >= 0 && vc <= v;
        if (op == OP_LL) res.feasible &= vt >= 0 && vt <= v;
        else res.feasible &= vt <= 0 && vt >= -v;
        if (rad < 0) begin
          lim = (e <<< 48) / (a * a);
          if (-rad > lim) res.feasible = 1'b0;
        end
        clipped = (rad < 0) ? wide_t'(0) : rad;
        if (clipped > peak2 || 2 * vc * vc > clipped) res.feasible = 1'b0;
        if (op == OP_LL && 2 * vt * vt > clipped) res.feasible = 1'b0;
      end
      OP_NEG_POS: begin
        res.duration = floor_time(vc + vt - root_of_twice(squares - dist2a), a);
        res.feasible = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  assign pending = awaited.size();

  always @(posedge clk) begin
    profile_t want;
    if (!rst_n) begin
      vel_limit <= 31'h0001_0000;
      acc_limit <= 31'h0001_0000;
      tolerance <= 16'd1;
      mismatches <= 0;
      awaited.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          {REG_VLIM, 2'b00}: vel_limit <= pwdata[LIM_W-1:0];
          {REG_ALIM, 2'b00}: acc_limit <= pwdata[LIM_W-1:0];
          {REG_TOL, 2'b00}:  tolerance <= pwdata[TOL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        awaited.push_back(predict_profile(in_operation, wide_t'(in_start_position),
                                          wide_t'(in_start_velocity),
                                          wide_t'(in_goal_position),
                                          wide_t'(in_goal_velocity)));
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          if (mismatches < 10) $display("unexpected result beat: time %h ok %b",
                                        out_profile_time, out_solution_possible);
          mismatches <= mismatches + 1;
        end else begin
          want = awaited.pop_front();
          if (want.duration !== out_profile_time || want.feasible !== out_solution_possible)
          begin
            if (mismatches < 10)
              $display("result mismatch: expected time %h ok %b, got time %h ok %b",
                       want.duration, want.feasible, out_profile_time,
                       out_solution_possible);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the profile time testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench import alpt_pkg::*; ();

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [2:0]              in_operation = '0;
  logic signed [VAL_W-1:0] in_start_position = '0;
  logic signed [VAL_W-1:0] in_start_velocity = '0;
  logic signed [VAL_W-1:0] in_goal_position = '0;
  logic signed [VAL_W-1:0] in_goal_velocity = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [QT_W-1:0]  out_profile_time;
  logic                    out_solution_possible;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;
  int                      mismatches;
  int                      pending;

  // Idle rates in percent for the sender and the receiver.
  int sender_idle = 0;
  int receiver_idle = 0;
  // Velocity limit currently in force, used to shape feasible beats.
  logic [LIM_W-1:0] vlim_now = 31'h0001_0000;

  always #4 clk = ~clk;

  accel_limited_profile_time_core dut (.*);

  profile_time_checker checker_i (.*);

  // The receiver stalls at random; each cycle gets a fresh draw.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < receiver_idle);
  end

  // A register write: a setup cycle, then an access cycle.
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_VLIM) vlim_now = value[LIM_W-1:0];
  endtask

  task automatic set_limits(logic [31:0] v, logic [31:0] a, logic [31:0] tol);
    write_reg(REG_VLIM, v);
    write_reg(REG_ALIM, a);
    write_reg(REG_TOL, tol);
  endtask

  // Offers one beat, with optional idle cycles ahead of it, and holds it
  // until the core takes it. in_valid stays high when beats follow directly.
  task automatic send_beat(logic [2:0] op, logic [31:0] pc, logic [31:0] vc,
                           logic [31:0] pt, logic [31:0] vt);
    while ($urandom_range(0, 99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_start_position <= pc;
    in_start_velocity <= vc;
    in_goal_position <= pt;
    in_goal_velocity <= vt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Waits until every expected result has come back, plus the pipeline depth.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  // Most random beats are well formed: velocities inside the limit with the
  // sign each shape wants and moderate distances, so the feasibility checks
  // are really exercised. The rest are raw bit patterns and spare selectors.
  task automatic random_beats(int count);
    logic [2:0]  op;
    logic [31:0] vc, vt, pc, span;
    logic [31:0] vmax;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 30) begin
        send_beat(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom);
      end else begin
        op = 3'($urandom_range(0, 4));
        vmax = (vlim_now == 0) ? 32'd1 : {1'b0, vlim_now};
        vc = $urandom_range(0, vmax);
        vt = $urandom_range(0, vmax);
        if (op == OP_TRI_NEG || op == OP_TRAP_NEG) vt = -vt;
        pc = $urandom;
        span = $signed($urandom) >>> $urandom_range(4, 31);
        send_beat(op, pc, vc, pc + span, vt);
      end
    end
  endtask

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under the reset limits of 1.0 and one LSB of tolerance.
    sender_idle = 33;
    receiver_idle = 88;
    // Feasible cruise shape, and the same with a negative goal velocity.
    send_beat(OP_LHL, 32'h0, 32'h0, 32'h0004_0000, 32'h0);
    send_beat(OP_TRAP_NEG, 32'h0, 32'h0000_8000, 32'h0004_0000, 32'hFFFF_8000);
    // Cruise shape too short to reach the limit, and a start above the limit.
    send_beat(OP_LHL, 32'h0, 32'h0, 32'h0000_4000, 32'h0);
    send_beat(OP_LHL, 32'h0, 32'h0002_0000, 32'h0004_0000, 32'h0);
    // Accel-decel shapes, feasible and with a peak above the limit.
    send_beat(OP_LL, 32'h0, 32'h0, 32'h0000_8000, 32'h0);
    send_beat(OP_LL, 32'h0, 32'h0, 32'h0010_0000, 32'h0);
    send_beat(OP_TRI_NEG, 32'h0, 32'h0, 32'h0000_8000, 32'hFFFF_C000);
    // Negative radicand: the root is clamped; in the accel-decel shape the tolerance decides.
    send_beat(OP_LL, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_beat(OP_LL, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0);
    send_beat(OP_NEG_POS, 32'h0, 32'h0001_0000, 32'h0000_4000, 32'h0001_0000);
    send_beat(OP_NEG_POS, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0);
    // Spare selectors give a zero time and no solution.
    send_beat(3'd5, 32'h1234_5678, 32'h0001_0000, 32'h0, 32'h0);
    send_beat(3'd6, 32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Field extremes drive the time into saturation both ways.
    send_beat(OP_LHL, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0);
    send_beat(OP_LHL, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);
    send_beat(OP_LL, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(OP_TRI_NEG, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(OP_TRAP_NEG, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
    send_beat(OP_NEG_POS, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(OP_NEG_POS, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();

    // Moderate limits with a loose tolerance.
    set_limits(32'h0002_0000, 32'h0001_8000, 32'd300);
    random_beats(160);
    drain();

    // Sender now the slow side; largest limits and tolerance.
    sender_idle = 88;
    receiver_idle = 33;
    set_limits(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd65535);
    random_beats(160);
    drain();

    // Zero limits act as one LSB; no tolerance at all.
    set_limits(32'h0, 32'h0, 32'h0);
    random_beats(150);
    drain();

    // Full rate on both sides with random limits.
    sender_idle = 0;
    receiver_idle = 0;
    set_limits($urandom_range(1, 32'h00FF_FFFF), $urandom_range(1, 32'h00FF_FFFF),
               $urandom_range(0, 65535));
    random_beats(160);
    drain();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/alpt_pkg.sv
src/alpt_front.sv
src/alpt_sqrt.sv
src/alpt_div.sv
src/accel_limited_profile_time_core.sv
tb/profile_time_checker.sv
tb/testbench.sv
